/* src/pfe_pkg.sv */
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared constants, codes and control structs of the postfix evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 16;
   localparam int FUNC_W      = 3;
   localparam int STAT_W      = 3;
   localparam int DIV_CNT_W   = $clog2(DATA_W);

   localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
   localparam logic [FUNC_W-1:0] FN_NEG  = 3'd1;
   localparam logic [FUNC_W-1:0] FN_ADD  = 3'd2;
   localparam logic [FUNC_W-1:0] FN_SUB  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_MUL  = 3'd4;
   localparam logic [FUNC_W-1:0] FN_DIV  = 3'd5;
   localparam logic [FUNC_W-1:0] FN_END  = 3'd6;

   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd1;
   localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd2;
   localparam logic [STAT_W-1:0] ST_DIVZERO  = 3'd3;
   localparam logic [STAT_W-1:0] ST_LEFTOVER = 3'd4;

   typedef struct packed {
      logic acc;
      logic push;
      logic rd_top;
      logic neg_wb;
      logic rd_sec;
      logic alu_wb;
      logic div_start;
      logic div_zero;
      logic div_wb;
      logic rd_bot;
      logic emit;
      logic err_under;
      logic err_over;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic lt2;
      logic full;
      logic is_div;
      logic r_zero;
      logic div_done;
      logic rsp_free;
   } sts_type;

endpackage

`default_nettype wire

/* src/pfe_div.sv */
// ----------------------------------------------------------------------------
// pfe_div
// Iterative signed 16-bit divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pfe_pkg::DATA_W-1:0]    dividend,
   input  wire logic [pfe_pkg::DATA_W-1:0]    divisor,
   output logic                               done,
   output logic [pfe_pkg::DATA_W-1:0]         quotient
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [pfe_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [pfe_pkg::DATA_W:0]       rem_ff, rem_in;
   logic [pfe_pkg::DATA_W-1:0]     quo_ff, quo_in;
   logic [pfe_pkg::DATA_W-1:0]     dvs_ff, dvs_in;
   logic                           neg_ff, neg_in;
   logic [pfe_pkg::DATA_W:0]       rem_sh;
   logic [pfe_pkg::DATA_W:0]       diff;

   always_comb begin
      rem_sh  = {rem_ff[pfe_pkg::DATA_W-1:0], quo_ff[pfe_pkg::DATA_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = pfe_pkg::DIV_CNT_W'(pfe_pkg::DATA_W - 1);
         rem_in  = '0;
         quo_in  = dividend[pfe_pkg::DATA_W-1] ? (~dividend + 1'b1) : dividend;
         dvs_in  = divisor[pfe_pkg::DATA_W-1] ? (~divisor + 1'b1) : divisor;
         neg_in  = dividend[pfe_pkg::DATA_W-1] ^ divisor[pfe_pkg::DATA_W-1];
      end else if (busy_ff) begin
         if (!diff[pfe_pkg::DATA_W]) begin
            rem_in = diff;
            quo_in = {quo_ff[pfe_pkg::DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[pfe_pkg::DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

`default_nettype wire

/* src/pfe_dpath.sv */
// ----------------------------------------------------------------------------
// pfe_dpath
// Operand stack memory, count and sticky error, ALU, divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pfe_pkg::cmd_type              cmd,
   output pfe_pkg::sts_type                   sts,
   input  wire logic [pfe_pkg::FUNC_W-1:0]    func,
   input  wire logic [pfe_pkg::DATA_W-1:0]    operand_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [pfe_pkg::DATA_W-1:0]         result_value,
   output logic [pfe_pkg::STAT_W-1:0]         status
);

   logic [pfe_pkg::DATA_W-1:0]     mem [pfe_pkg::STACK_DEPTH];
   logic [pfe_pkg::DATA_W-1:0]     rd_data_ff;
   logic [pfe_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [pfe_pkg::STAT_W-1:0]     err_ff, err_in;
   logic [pfe_pkg::FUNC_W-1:0]     func_ff;
   logic [pfe_pkg::DATA_W-1:0]     opr_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pfe_pkg::DATA_W-1:0]     rsp_value_ff;
   logic [pfe_pkg::STAT_W-1:0]     rsp_status_ff;
   logic [pfe_pkg::CNT_W-1:0]      cnt_m1, cnt_m2;
   logic                           wr_en, rd_en;
   logic [pfe_pkg::ADDR_W-1:0]     wr_addr, rd_addr;
   logic [pfe_pkg::DATA_W-1:0]     wr_data;
   logic [2*pfe_pkg::DATA_W-1:0]   prod;
   logic [pfe_pkg::DATA_W-1:0]     alu_res;
   logic [pfe_pkg::STAT_W-1:0]     end_status;
   logic                           div_done;
   logic [pfe_pkg::DATA_W-1:0]     div_quo;

   pfe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rd_data_ff),
      .divisor  (opr_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      cnt_m1 = count_ff - 1'b1;
      cnt_m2 = count_ff - 2'd2;
      prod   = rd_data_ff * opr_ff;
      case (func_ff)
         pfe_pkg::FN_ADD: alu_res = rd_data_ff + opr_ff;
         pfe_pkg::FN_SUB: alu_res = rd_data_ff - opr_ff;
         default:         alu_res = prod[pfe_pkg::DATA_W-1:0];
      endcase

      wr_en   = cmd.push | cmd.neg_wb | cmd.alu_wb | cmd.div_zero | cmd.div_wb;
      wr_addr = cnt_m2[pfe_pkg::ADDR_W-1:0];
      wr_data = '0;
      if (cmd.push) begin
         wr_addr = count_ff[pfe_pkg::ADDR_W-1:0];
         wr_data = operand_value;
      end else if (cmd.neg_wb) begin
         wr_addr = cnt_m1[pfe_pkg::ADDR_W-1:0];
         wr_data = ~rd_data_ff + 1'b1;
      end else if (cmd.alu_wb) begin
         wr_data = alu_res;
      end else if (cmd.div_wb) begin
         wr_data = div_quo;
      end

      rd_en   = cmd.rd_top | cmd.rd_sec | cmd.rd_bot;
      rd_addr = '0;
      if (cmd.rd_top) begin
         rd_addr = cnt_m1[pfe_pkg::ADDR_W-1:0];
      end else if (cmd.rd_sec) begin
         rd_addr = cnt_m2[pfe_pkg::ADDR_W-1:0];
      end

      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.alu_wb || cmd.div_zero || cmd.div_wb) begin
         count_in = cnt_m1;
      end else if (cmd.emit) begin
         count_in = '0;
      end

      err_in = err_ff;
      if (cmd.emit) begin
         err_in = pfe_pkg::ST_OK;
      end else if (err_ff == pfe_pkg::ST_OK) begin
         if (cmd.err_under) begin
            err_in = pfe_pkg::ST_UNDERFLOW;
         end else if (cmd.err_over) begin
            err_in = pfe_pkg::ST_OVERFLOW;
         end else if (cmd.div_zero) begin
            err_in = pfe_pkg::ST_DIVZERO;
         end
      end

      if (err_ff != pfe_pkg::ST_OK) begin
         end_status = err_ff;
      end else if (count_ff != pfe_pkg::CNT_W'(1)) begin
         end_status = pfe_pkg::ST_LEFTOVER;
      end else begin
         end_status = pfe_pkg::ST_OK;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         err_ff       <= pfe_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.acc) begin
         func_ff <= func;
      end
      if (cmd.rd_sec) begin
         opr_ff <= rd_data_ff;
      end
      if (cmd.emit) begin
         rsp_status_ff <= end_status;
         rsp_value_ff  <= (end_status == pfe_pkg::ST_OK) ? rd_data_ff : '0;
      end
   end

   always_comb begin
      sts.empty    = (count_ff == '0);
      sts.lt2      = (count_ff < pfe_pkg::CNT_W'(2));
      sts.full     = (count_ff == pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH));
      sts.is_div   = (func_ff == pfe_pkg::FN_DIV);
      sts.r_zero   = (opr_ff == '0);
      sts.div_done = div_done;
      sts.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign result_value = rsp_value_ff;
   assign status       = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.r_zero)
      else $error("divider started on zero divisor");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (count_ff == '0) && (err_ff == pfe_pkg::ST_OK) && rsp_valid_ff)
      else $error("end item did not clear state");

   a_err_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != pfe_pkg::ST_OK) |-> (rsp_value_ff == '0))
      else $error("nonzero value with error status");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !sts.full)
      else $error("push on full stack");

endmodule

`default_nettype wire

/* src/pfe_ctrl.sv */
// ----------------------------------------------------------------------------
// pfe_ctrl
// Token sequencer: accepts items and steps the datapath through each token.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [pfe_pkg::FUNC_W-1:0]    func,
   input  wire pfe_pkg::sts_type              sts,
   output pfe_pkg::cmd_type                   cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_NEG  = 3'd1;
   localparam logic [2:0] S_CAPR = 3'd2;
   localparam logic [2:0] S_EXEC = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_END  = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.acc = 1'b1;
               case (func)
                  pfe_pkg::FN_PUSH: begin
                     if (sts.full) begin
                        cmd.err_over = 1'b1;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end
                  pfe_pkg::FN_NEG: begin
                     if (sts.empty) begin
                        cmd.err_under = 1'b1;
                     end else begin
                        cmd.rd_top = 1'b1;
                        state_in   = S_NEG;
                     end
                  end
                  pfe_pkg::FN_ADD, pfe_pkg::FN_SUB, pfe_pkg::FN_MUL, pfe_pkg::FN_DIV: begin
                     if (sts.lt2) begin
                        cmd.err_under = 1'b1;
                     end else begin
                        cmd.rd_top = 1'b1;
                        state_in   = S_CAPR;
                     end
                  end
                  pfe_pkg::FN_END: begin
                     cmd.rd_bot = 1'b1;
                     state_in   = S_END;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_NEG: begin
            cmd.neg_wb = 1'b1;
            state_in   = S_IDLE;
         end
         S_CAPR: begin
            cmd.rd_sec = 1'b1;
            state_in   = S_EXEC;
         end
         S_EXEC: begin
            if (!sts.is_div) begin
               cmd.alu_wb = 1'b1;
               state_in   = S_IDLE;
            end else if (sts.r_zero) begin
               cmd.div_zero = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.div_wb = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_END: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* src/postfix_int16_evaluator_top.sv */
// ----------------------------------------------------------------------------
// postfix_int16_evaluator_top
// Postfix token evaluator with a 64-entry operand stack and 16-bit wrapping
// arithmetic; the end token returns the value and a status.
// Push completes on acceptance; negate reads and rewrites the top; add, sub
// and mul read both operands, then write back; divide runs the iterative
// divider unless the divisor is zero; end's result waits for an earlier one.
// One token is in work at a time; the result register lets the next token
// be taken while a result waits. Synchronous reset empties the stack and
// clears the error and the result valid flag; stack memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_int16_evaluator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] operand_value
   input  wire logic [2:0]  req_tuser,   // [2:0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // [15:0] result_value, [18:16] status
);

   pfe_pkg::cmd_type                cmd;
   pfe_pkg::sts_type                sts;
   logic [pfe_pkg::DATA_W-1:0]      result_value;
   logic [pfe_pkg::STAT_W-1:0]      status;

   pfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .func      (req_tuser),
      .sts       (sts),
      .cmd       (cmd)
   );

   pfe_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .func          (req_tuser),
      .operand_value (req_tdata),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .result_value  (result_value),
      .status        (status)
   );

   assign rsp_tdata = {5'b0, status, result_value};

endmodule

`default_nettype wire

/* sim/postfix_int16_evaluator_top_test.sv */
// ----------------------------------------------------------------------------
// postfix_int16_evaluator_top_test
// Streams postfix token sequences into the evaluator and checks every result
// item (value and status) against a shadow stack evaluated in this bench.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_int16_evaluator_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [pfe_pkg::FUNC_W-1:0] FN_UNUSED   = 3'd7;
   localparam int                         TOKEN_COUNT = 1800;
   localparam int                         CYCLE_LIMIT = 400000;
   localparam int                         HOLD_CYCLES = 400;
   localparam int                         SYNC_EVERY  = 600;

   typedef struct packed {
      logic                       sync;
      logic [2:0]                 gap;
      logic [pfe_pkg::FUNC_W-1:0] func;
      logic [pfe_pkg::DATA_W-1:0] value;
   } token_type;

   typedef struct packed {
      logic [pfe_pkg::DATA_W-1:0] value;
      logic [pfe_pkg::STAT_W-1:0] status;
   } eval_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   token_type       token_queue[$];
   eval_result_type pending_results[$];

   logic [pfe_pkg::DATA_W-1:0] shadow_stack [0:pfe_pkg::STACK_DEPTH-1];
   int unsigned                shadow_count = 0;
   logic [pfe_pkg::STAT_W-1:0] shadow_error = pfe_pkg::ST_OK;

   token_type drv_item;
   logic   drv_loaded      = 1'b0;
   int     drv_wait        = 0;
   int     accepted_tokens = 0;
   int     rsp_wait        = 0;
   int     rsp_seen        = 0;
   logic   rsp_hold        = 1'b0;
   int     error_count     = 0;
   int     cycle_count     = 0;
   int     gen_count       = 0;
   int     next_sync       = SYNC_EVERY;

   postfix_int16_evaluator_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic void flag_error(input logic [pfe_pkg::STAT_W-1:0] code);
      if (shadow_error == pfe_pkg::ST_OK) shadow_error = code;
   endfunction

   function automatic void evaluate_token(input logic [pfe_pkg::FUNC_W-1:0] fn,
                                          input logic [pfe_pkg::DATA_W-1:0] lit);
      logic [pfe_pkg::DATA_W-1:0] rhs;
      logic [pfe_pkg::DATA_W-1:0] lhs;
      logic [pfe_pkg::DATA_W-1:0] res;
      int                         quot;
      eval_result_type            r;
      case (fn)
         pfe_pkg::FN_PUSH: begin
            if (shadow_count >= pfe_pkg::STACK_DEPTH) flag_error(pfe_pkg::ST_OVERFLOW);
            else begin
               shadow_stack[shadow_count] = lit;
               shadow_count++;
            end
         end
         pfe_pkg::FN_NEG: begin
            if (shadow_count < 1) flag_error(pfe_pkg::ST_UNDERFLOW);
            else shadow_stack[shadow_count-1] = -shadow_stack[shadow_count-1];
         end
         pfe_pkg::FN_ADD, pfe_pkg::FN_SUB, pfe_pkg::FN_MUL, pfe_pkg::FN_DIV: begin
            if (shadow_count < 2) flag_error(pfe_pkg::ST_UNDERFLOW);
            else begin
               rhs = shadow_stack[shadow_count-1];
               lhs = shadow_stack[shadow_count-2];
               case (fn)
                  pfe_pkg::FN_ADD: res = lhs + rhs;
                  pfe_pkg::FN_SUB: res = lhs - rhs;
                  pfe_pkg::FN_MUL: res = lhs * rhs;
                  default: begin
                     if (rhs == '0) begin
                        flag_error(pfe_pkg::ST_DIVZERO);
                        res = '0;
                     end else begin
                        quot = int'($signed(lhs)) / int'($signed(rhs));
                        res  = quot[pfe_pkg::DATA_W-1:0];
                     end
                  end
               endcase
               shadow_stack[shadow_count-2] = res;
               shadow_count--;
            end
         end
         pfe_pkg::FN_END: begin
            if (shadow_error != pfe_pkg::ST_OK) r.status = shadow_error;
            else if (shadow_count != 1) r.status = pfe_pkg::ST_LEFTOVER;
            else r.status = pfe_pkg::ST_OK;
            r.value = (r.status == pfe_pkg::ST_OK) ? shadow_stack[0] : '0;
            pending_results.push_back(r);
            shadow_count = 0;
            shadow_error = pfe_pkg::ST_OK;
         end
         default: ;
      endcase
   endfunction

   function automatic void check_result(input logic [23:0] data);
      eval_result_type want;
      if (pending_results.size() == 0) begin
         $error("result item with none expected: rsp_tdata %h", data);
         error_count++;
      end else begin
         want = pending_results.pop_front();
         if (data[15:0] !== want.value) begin
            $error("result_value: expected %0d, actual %0d",
                   $signed(want.value), $signed(data[15:0]));
            error_count++;
         end
         if (data[18:16] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, data[18:16]);
            error_count++;
         end
         if (data[23:19] !== 5'd0) begin
            $error("pad: expected 0, actual %h", data[23:19]);
            error_count++;
         end
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         drv_loaded = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            evaluate_token(drv_item.func, drv_item.value);
            accepted_tokens++;
            drv_loaded = 1'b0;
         end
         if (!drv_loaded && token_queue.size() > 0) begin
            if (token_queue[0].sync) begin
               if (pending_results.size() == 0) token_queue.delete(0);
            end else begin
               drv_item   = token_queue.pop_front();
               drv_wait   = drv_item.gap;
               drv_loaded = 1'b1;
            end
         end
         if (drv_loaded && drv_wait == 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= drv_item.value;
            req_tuser  <= drv_item.func;
         end else begin
            if (drv_loaded) drv_wait--;
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result(rsp_tdata);
            rsp_seen++;
            rsp_wait = (rsp_seen % 32 < 8) ? 0 : $urandom_range(0, 5);
         end
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // hold off results for a long stretch while tokens keep coming
   initial begin
      while (accepted_tokens < 800) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic add_token(input logic [pfe_pkg::FUNC_W-1:0] fn,
                            input logic [pfe_pkg::DATA_W-1:0] val,
                            input bit burst);
      token_type t;
      t.sync  = 1'b0;
      t.gap   = burst ? 3'd0 : 3'($urandom_range(0, 5));
      t.func  = fn;
      t.value = val;
      token_queue.push_back(t);
      if (fn != FN_UNUSED) gen_count++;
   endtask

   task automatic add_sync();
      token_type t;
      t      = '0;
      t.sync = 1'b1;
      token_queue.push_back(t);
   endtask

   function automatic logic [pfe_pkg::DATA_W-1:0] pick_literal();
      logic [pfe_pkg::DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = 16'h0000;
         1: v = 16'h0001;
         2: v = 16'hFFFF;
         3: v = 16'h7FFF;
         4: v = 16'h8000;
         5, 6: v = 16'($urandom_range(0, 16)) - 16'd8;
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   task automatic add_expression(input int n_lits, input bit deep);
      int pending;
      int live;
      bit burst;
      burst   = ($urandom_range(0, 3) == 0);
      pending = n_lits;
      live    = 0;
      while (pending > 0 || live > 1) begin
         if (live >= 2 && (pending == 0 || (!deep && $urandom_range(0, 2) == 0))) begin
            add_token(3'($urandom_range(pfe_pkg::FN_ADD, pfe_pkg::FN_DIV)),
                      16'($urandom), burst);
            live--;
         end else if (live >= 1 && $urandom_range(0, 7) == 0) begin
            add_token(pfe_pkg::FN_NEG, 16'($urandom), burst);
         end else begin
            add_token(pfe_pkg::FN_PUSH, pick_literal(), burst);
            pending--;
            live++;
         end
      end
      if ($urandom_range(0, 15) == 0)
         add_token(3'($urandom_range(pfe_pkg::FN_NEG, pfe_pkg::FN_DIV)),
                   16'($urandom), burst);
      add_token(pfe_pkg::FN_END, 16'($urandom), burst);
   endtask

   initial begin
      int n;
      int sel;

      // wrap on subtract at the extremes
      add_token(pfe_pkg::FN_PUSH, 16'h7FFF, 1'b0);
      add_token(pfe_pkg::FN_PUSH, 16'h8000, 1'b0);
      add_token(pfe_pkg::FN_SUB,  16'h0000, 1'b0);
      add_token(pfe_pkg::FN_END,  16'hFFFF, 1'b0);
      // most negative over minus one, then negate of most negative
      add_token(pfe_pkg::FN_PUSH, 16'h8000, 1'b1);
      add_token(pfe_pkg::FN_PUSH, 16'hFFFF, 1'b1);
      add_token(pfe_pkg::FN_DIV,  16'h0000, 1'b1);
      add_token(pfe_pkg::FN_NEG,  16'h0000, 1'b1);
      add_token(pfe_pkg::FN_END,  16'h0000, 1'b1);
      // truncating divide, wrapping multiply, add
      add_token(pfe_pkg::FN_PUSH, -16'sd7, 1'b0);
      add_token(pfe_pkg::FN_PUSH, 16'd2,   1'b0);
      add_token(pfe_pkg::FN_DIV,  16'h0000, 1'b0);
      add_token(pfe_pkg::FN_PUSH, 16'd300, 1'b0);
      add_token(pfe_pkg::FN_MUL,  16'h0000, 1'b0);
      add_token(pfe_pkg::FN_PUSH, 16'h7FFF, 1'b0);
      add_token(pfe_pkg::FN_ADD,  16'h0000, 1'b0);
      add_token(pfe_pkg::FN_END,  16'h0000, 1'b0);
      // divide by zero, then underflow stays hidden behind it
      add_token(pfe_pkg::FN_PUSH, 16'd5,   1'b0);
      add_token(pfe_pkg::FN_PUSH, 16'd0,   1'b0);
      add_token(pfe_pkg::FN_DIV,  16'h0000, 1'b0);
      add_token(pfe_pkg::FN_ADD,  16'h0000, 1'b0);
      add_token(pfe_pkg::FN_END,  16'h0000, 1'b0);
      // empty stack at end
      add_token(pfe_pkg::FN_END,  16'h0000, 1'b0);
      // negate on empty stack, unused kind ignored
      add_token(pfe_pkg::FN_NEG,  16'h0000, 1'b0);
      add_token(pfe_pkg::FN_PUSH, 16'd3,    1'b0);
      add_token(FN_UNUSED,        16'hFFFF, 1'b0);
      add_token(pfe_pkg::FN_END,  16'h0000, 1'b0);
      add_sync();

      while (gen_count < TOKEN_COUNT) begin
         sel = $urandom_range(0, 99);
         if (sel < 3) begin
            add_expression($urandom_range(62, 66), 1'b1);
         end else if (sel < 13) begin
            n = $urandom_range(1, 6);
            repeat (n) add_token(3'($urandom_range(0, 7)), 16'($urandom), 1'b0);
         end else begin
            add_expression($urandom_range(1, 8), 1'b0);
         end
         if (gen_count >= next_sync) begin
            add_sync();
            next_sync += SYNC_EVERY;
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (token_queue.size() != 0 || drv_loaded) @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
src/pfe_pkg.sv
src/pfe_div.sv
src/pfe_dpath.sv
src/pfe_ctrl.sv
src/postfix_int16_evaluator_top.sv
sim/postfix_int16_evaluator_top_test.sv
